@@ rtl/core/evcb_pkg.sv @@
package evcb_pkg;

    // Widths of the configuration registers and the chunk length fields.
    localparam int THR_BITS   = 30;
    localparam int CHUNK_BITS = 20;
    localparam int CFG_IDX_BITS = 2;

    // Default parameter values for the top level.
    localparam int COUNT_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 16;

    // Depth of the job queue between the accumulator and the decision pipeline.
    localparam int QUEUE_DEPTH = 4;

    // Register reset values.
    localparam logic [THR_BITS-1:0]   THR_LEVEL_RST = 30'd107374;
    localparam logic [CHUNK_BITS-1:0] MIN_CHUNK_RST = 20'd64000;
    localparam logic [CHUNK_BITS-1:0] MAX_CHUNK_RST = 20'd320000;
    localparam logic [CHUNK_BITS-1:0] PAD_LEN_RST   = 20'd2400;

    // Largest value of a chunk length field.
    localparam logic [CHUNK_BITS-1:0] CHUNK_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THR_LEVEL = 2'd0,
        CFG_MIN_CHUNK = 2'd1,
        CFG_MAX_CHUNK = 2'd2,
        CFG_PAD_LEN   = 2'd3
    } cfg_idx_t;

    // Status of the job queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // Width of the energy accumulator: a full-scale square per sample over a
    // saturated count, held to 63 bits.
    function automatic int energy_bits(input int sample_bits, input int count_bits);
        int w;
        begin
            w = 2 * (sample_bits - 1) + 1 + count_bits;
            energy_bits = (w > 63) ? 63 : w;
        end
    endfunction

endpackage

@@ rtl/core/energy_vad_chunk_boundary_core.sv @@
// Energy voice activity detector with chunk boundary decision.
// Input channel: one audio sample per beat (in_valid/in_ready) with flags
// last_of_buffer and end_of_stream. Every sample is squared and added to a
// saturating energy total while a saturating sample count advances.
// Output channel: one result beat (out_valid/out_ready) for each input beat
// that carries last_of_buffer; other beats give no result.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 squared
// energy threshold, 1 min_chunk, 2 max_chunk, 3 pad_len); the user must write
// only while the block is idle, as the block itself does not enforce it.
// Throughput: one sample per cycle sustained while no last-of-buffer sample
// waits on a full queue. The front takes samples through a square stage and an
// accumulator; the back runs the threshold multiply and the decision as two
// pipelined stages. Path: a last sample is squared, accumulated into the job
// queue, multiplied and decided into the output register.
// Reset: registers take their defaults and the totals clear; no start-up sweep.
// Output stall: the output register holds, the multiply stage and the 4-entry
// job queue fill, and only a last-of-buffer sample meeting a full queue stops
// the input; ordinary samples keep flowing into the totals.
module energy_vad_chunk_boundary_core #(
    parameter int COUNT_BITS  = evcb_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = evcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [evcb_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [evcb_pkg::THR_BITS-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              last_of_buffer,
    input  logic                              end_of_stream,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              speech_found,
    output logic                              boundary_found,
    output logic [evcb_pkg::CHUNK_BITS-1:0]   cut_samples,
    output logic [evcb_pkg::CHUNK_BITS-1:0]   silence_drain
);

    localparam int ENERGY_BITS = evcb_pkg::energy_bits(SAMPLE_BITS, COUNT_BITS);
    localparam int JOB_W       = ENERGY_BITS + COUNT_BITS + 1;

    evcb_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    logic [JOB_W-1:0]  push_data;
    logic [JOB_W-1:0]  pop_data;

    // Sample intake and buffer totals.
    evcb_front #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .last_of_buffer (last_of_buffer),
        .end_of_stream  (end_of_stream),
        .q_stat         (q_stat),
        .push           (push),
        .push_data      (push_data)
    );

    // Buffer totals waiting for a decision.
    evcb_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (evcb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Speech decision and chunk boundary.
    evcb_back #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .q_stat         (q_stat),
        .pop_data       (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speech_found   (speech_found),
        .boundary_found (boundary_found),
        .cut_samples    (cut_samples),
        .silence_drain  (silence_drain)
    );

endmodule

@@ rtl/core/evcb_front.sv @@
module evcb_front #(
    parameter int COUNT_BITS  = evcb_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = evcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_of_buffer,
    input  logic                          end_of_stream,
    input  evcb_pkg::q_stat_t             q_stat,
    output logic                          push,
    output logic [evcb_pkg::energy_bits(SAMPLE_BITS, COUNT_BITS)+COUNT_BITS:0] push_data
);

    localparam int ENERGY_BITS = evcb_pkg::energy_bits(SAMPLE_BITS, COUNT_BITS);
    localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;

    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] sq_full;

    logic                   s1_valid_reg, s1_valid_next;
    logic [SQ_BITS-1:0]     s1_sq_reg;
    logic                   s1_last_reg;
    logic                   s1_eos_reg;
    logic                   s1_adv;
    logic                   accept;

    logic [ENERGY_BITS-1:0] energy_reg, energy_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [ENERGY_BITS:0]   energy_add;
    logic [ENERGY_BITS-1:0] energy_sat;
    logic [COUNT_BITS-1:0]  count_sat;

    // Square of the magnitude; the most negative code squares to 2^(2N-2).
    assign raw     = sample;
    assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign sq_full = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

    // The square stage only waits when it holds a last beat and the queue is full.
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !q_stat.full);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg   <= sq_full[SQ_BITS-1:0];
            s1_last_reg <= last_of_buffer;
            s1_eos_reg  <= end_of_stream;
        end
    end

    // Saturating accumulation of energy and sample count.
    assign energy_add = {1'b0, energy_reg} + (ENERGY_BITS+1)'(s1_sq_reg);
    assign energy_sat = energy_add[ENERGY_BITS] ? '1 : energy_add[ENERGY_BITS-1:0];
    assign count_sat  = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // A last beat hands the buffer totals to the queue and clears the totals.
    assign push      = s1_adv && s1_last_reg;
    assign push_data = {energy_sat, count_sat, s1_eos_reg};

    always_comb
    begin
        energy_next = energy_reg;
        count_next  = count_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                energy_next = '0;
                count_next  = '0;
            end
            else
            begin
                energy_next = energy_sat;
                count_next  = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
            count_reg  <= count_next;
        end
    end

    // A beat is refused only while a last beat is blocked on a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_last_reg && q_stat.full))
        else $error("front stalled without a blocked last beat");

endmodule

@@ rtl/core/evcb_queue.sv @@
module evcb_queue #(
    parameter int DATA_W = 72,
    parameter int DEPTH  = evcb_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output evcb_pkg::q_stat_t q_stat
);

    // DEPTH is a power of two so the pointers wrap on their own.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full      = (fill_reg == (PTR_W+1)'(DEPTH));
    assign q_stat.not_empty = (fill_reg != '0);
    assign do_push          = push && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;
    assign pop_data         = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // The producer must never offer a job to a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    // The fill level tracks the pointer distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != (PTR_W+1)'(DEPTH)) |-> (fill_reg[PTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("queue fill level out of step with pointers");

endmodule

@@ rtl/core/evcb_back.sv @@
module evcb_back #(
    parameter int COUNT_BITS  = evcb_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = evcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [evcb_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
    input  logic [evcb_pkg::THR_BITS-1:0]          cfg_wdata,
    input  evcb_pkg::q_stat_t                      q_stat,
    input  logic [evcb_pkg::energy_bits(SAMPLE_BITS, COUNT_BITS)+COUNT_BITS:0] pop_data,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   speech_found,
    output logic                                   boundary_found,
    output logic [evcb_pkg::CHUNK_BITS-1:0]        cut_samples,
    output logic [evcb_pkg::CHUNK_BITS-1:0]        silence_drain
);

    localparam int ENERGY_BITS = evcb_pkg::energy_bits(SAMPLE_BITS, COUNT_BITS);
    localparam int CB          = evcb_pkg::CHUNK_BITS;
    localparam int PROD_W      = evcb_pkg::THR_BITS + COUNT_BITS;
    localparam int CMP_W       = (ENERGY_BITS > PROD_W) ? ENERGY_BITS : PROD_W;
    localparam int CW          = (COUNT_BITS > CB) ? COUNT_BITS : CB;

    logic [evcb_pkg::THR_BITS-1:0] thr_level_reg;
    logic [CB-1:0]                 min_chunk_reg;
    logic [CB-1:0]                 max_chunk_reg;
    logic [CB-1:0]                 pad_len_reg;

    logic [ENERGY_BITS-1:0] q_energy;
    logic [COUNT_BITS-1:0]  q_count;
    logic                   q_eos;

    logic                   p_valid_reg, p_valid_next;
    logic [ENERGY_BITS-1:0] p_energy_reg;
    logic [COUNT_BITS-1:0]  p_count_reg;
    logic                   p_eos_reg;
    logic [PROD_W-1:0]      p_prod_reg;
    logic [CB-1:0]          p_target_reg;
    logic [CB:0]            target_sum;

    logic          o_valid_reg, o_valid_next;
    logic          speech_reg, speech_next;
    logic          boundary_reg, boundary_next;
    logic [CB-1:0] cut_reg, cut_next;
    logic [CB-1:0] drain_reg, drain_next;

    logic          o_free;
    logic          p_free;
    logic [CW-1:0] cnt_w;
    logic [CW-1:0] min_w;
    logic [CW-1:0] pad_w;
    logic [CW-1:0] tgt_w;
    logic [CW-1:0] drain_w;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_level_reg <= evcb_pkg::THR_LEVEL_RST;
            min_chunk_reg <= evcb_pkg::MIN_CHUNK_RST;
            max_chunk_reg <= evcb_pkg::MAX_CHUNK_RST;
            pad_len_reg   <= evcb_pkg::PAD_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (evcb_pkg::cfg_idx_t'(cfg_idx))
                evcb_pkg::CFG_THR_LEVEL: thr_level_reg <= cfg_wdata;
                evcb_pkg::CFG_MIN_CHUNK: min_chunk_reg <= cfg_wdata[CB-1:0];
                evcb_pkg::CFG_MAX_CHUNK: max_chunk_reg <= cfg_wdata[CB-1:0];
                evcb_pkg::CFG_PAD_LEN:   pad_len_reg   <= cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: each stage moves when the one after it is free.
    assign o_free = !o_valid_reg || out_ready;
    assign p_free = !p_valid_reg || o_free;
    assign pop    = q_stat.not_empty && p_free;

    assign {q_energy, q_count, q_eos} = pop_data;
    assign target_sum = {1'b0, min_chunk_reg} + {1'b0, max_chunk_reg};

    always_comb
    begin
        p_valid_next = pop ? 1'b1 : (o_free ? 1'b0 : p_valid_reg);
        o_valid_next = (p_valid_reg && o_free) ? 1'b1 :
                       (out_ready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Product stage: threshold times count, and the cut target.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_energy_reg <= q_energy;
            p_count_reg  <= q_count;
            p_eos_reg    <= q_eos;
            p_prod_reg   <= PROD_W'(thr_level_reg) * PROD_W'(q_count);
            p_target_reg <= target_sum[CB:1];
        end
    end

    // Decision stage: speech test, then a cut or a drain when a boundary is due.
    assign cnt_w = CW'(p_count_reg);
    assign min_w = CW'(min_chunk_reg);
    assign pad_w = CW'(pad_len_reg);
    assign tgt_w = CW'(p_target_reg);
    assign drain_w = (p_eos_reg || (cnt_w <= pad_w)) ? cnt_w : cnt_w - pad_w;

    always_comb
    begin
        speech_next   = CMP_W'(p_energy_reg) > CMP_W'(p_prod_reg);
        boundary_next = 1'b0;
        cut_next      = '0;
        drain_next    = '0;
        if (!speech_next)
        begin
            if ((cnt_w >= min_w) || p_eos_reg)
            begin
                boundary_next = 1'b1;
                drain_next    = (drain_w > CW'(evcb_pkg::CHUNK_MAX)) ?
                                evcb_pkg::CHUNK_MAX : drain_w[CB-1:0];
            end
        end
        else
        begin
            if ((cnt_w >= tgt_w) || p_eos_reg)
            begin
                boundary_next = 1'b1;
                cut_next      = (cnt_w > tgt_w) ? p_target_reg : cnt_w[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg && o_free)
        begin
            speech_reg   <= speech_next;
            boundary_reg <= boundary_next;
            cut_reg      <= cut_next;
            drain_reg    <= drain_next;
        end
    end

    assign out_valid      = o_valid_reg;
    assign speech_found   = speech_reg;
    assign boundary_found = boundary_reg;
    assign cut_samples    = cut_reg;
    assign silence_drain  = drain_reg;

    // Without a boundary there is neither a cut nor a drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !boundary_found) |-> (cut_samples == '0 && silence_drain == '0))
        else $error("chunk length reported without a boundary");

    // A cut only comes with speech, a drain only with silence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((speech_found && silence_drain == '0) ||
                       (!speech_found && cut_samples == '0)))
        else $error("cut and drain disagree with the speech decision");

endmodule
